/* src/sdc_pkg.sv */
// Shared types and constants for the SPI-mode SD card model.
// Used by sdc_card_core and sd_card_spi_slave; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

	// Image store: power-of-two depth, so address wrap is a plain carry-out.
	localparam int POS_W       = 16;
	localparam int IMAGE_BYTES = 1 << POS_W;

	// Bus access kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Register window
	localparam logic [1:0] ADDR_DATA     = 2'd0;
	localparam logic [1:0] ADDR_EXCHANGE = 2'd1;
	localparam logic [1:0] ADDR_SELECT   = 2'd2;
	localparam logic [1:0] ADDR_DESELECT = 2'd3;

	localparam logic [7:0] BYTE_IDLE = 8'hFF;

	typedef struct packed {
		logic       action;
		logic [1:0] addr;
		logic [7:0] data;
	} sdc_item_t;

	typedef struct packed {
		logic             we;
		logic [POS_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [POS_W-1:0] raddr;
	} sdc_mem_req_t;

endpackage

`default_nettype wire

/* src/sdc_image_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
// Forwards a same-cycle write to the read port. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sdc_image_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

/* src/sdc_card_core.sv */
// Bus register window and SPI-mode card state machine; one beat per fire.
// Depends on sdc_pkg; reads image bytes prefetched by the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdc_card_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire sdc_pkg::sdc_item_t   item,
	input  wire logic                 card_present,
	input  wire logic [7:0]           rdata,
	output logic [7:0]                result,
	output sdc_pkg::sdc_mem_req_t     mem_req
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_CMD      = 4'd1;
	localparam logic [3:0] PH_RESP     = 4'd2;
	localparam logic [3:0] PH_SRD_RESP = 4'd3;
	localparam logic [3:0] PH_SRD      = 4'd4;
	localparam logic [3:0] PH_MRD_RESP = 4'd5;
	localparam logic [3:0] PH_MRD      = 4'd6;
	localparam logic [3:0] PH_WR_RESP  = 4'd7;
	localparam logic [3:0] PH_WR       = 4'd8;

	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_SEND_OP    = 6'd1;
	localparam logic [5:0] CMD_STOP       = 6'd12;
	localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
	localparam logic [5:0] CMD_READ_ONE   = 6'd17;
	localparam logic [5:0] CMD_READ_MULTI = 6'd18;
	localparam logic [5:0] CMD_WRITE_ONE  = 6'd24;

	localparam logic [7:0] R1_IDLE     = 8'h01;
	localparam logic [7:0] R1_READY    = 8'h00;
	localparam logic [7:0] DATA_TOKEN  = 8'hFE;
	localparam logic [7:0] DATA_ACCEPT = 8'h05;
	localparam logic [1:0] START_BITS  = 2'b01;
	localparam int         FRAME_KEEP  = 5;

	logic [7:0]             tx_q, tx_d;
	logic [7:0]             rx_q, rx_d;
	logic                   sel_q, sel_d;
	logic [3:0]             phase_q, phase_d;
	logic [31:0]            cnt_q, cnt_d;
	logic [7:0]             pend_q, pend_d;
	logic [31:0]            bl_q, bl_d;
	logic [32:0]            blp2_q, blp2_d;
	logic [32:0]            blp4_q, blp4_d;
	logic [sdc_pkg::POS_W-1:0] pos_q, pos_d;
	logic [7:0]             frame_q [FRAME_KEEP];

	logic        take;
	logic [31:0] tcnt;
	logic        rd;
	logic        frame_we;
	logic [2:0]  frame_idx;
	logic [31:0] arg;
	logic [7:0]  ex_out;
	logic [7:0]  in_byte;

	assign in_byte = tx_q;
	assign arg     = {frame_q[1], frame_q[2], frame_q[3], frame_q[4]};

	always_comb begin
		tx_d      = tx_q;
		rx_d      = rx_q;
		sel_d     = sel_q;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		pend_d    = pend_q;
		bl_d      = bl_q;
		blp2_d    = blp2_q;
		blp4_d    = blp4_q;
		pos_d     = pos_q;
		result    = sdc_pkg::BYTE_IDLE;
		ex_out    = sdc_pkg::BYTE_IDLE;
		take      = 1'b0;
		tcnt      = '0;
		rd        = 1'b0;
		frame_we  = 1'b0;
		frame_idx = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = in_byte;

		if (fire && item.action == sdc_pkg::ACT_READ) begin
			if (item.addr == sdc_pkg::ADDR_DATA && card_present) begin
				result = rx_q;
			end
		end else if (fire) begin
			case (item.addr)
				sdc_pkg::ADDR_DATA: begin
					tx_d = item.data;
				end
				sdc_pkg::ADDR_EXCHANGE: begin
					if (card_present && sel_q) begin
						case (phase_q)
							PH_IDLE: begin
								if (in_byte[7:6] == START_BITS) begin
									phase_d = PH_CMD;
									take    = 1'b1;
								end
							end
							PH_CMD: begin
								take = 1'b1;
								tcnt = cnt_q;
							end
							PH_RESP: begin
								ex_out  = pend_q;
								phase_d = PH_IDLE;
							end
							PH_SRD_RESP: begin
								ex_out  = pend_q;
								phase_d = PH_SRD;
								cnt_d   = '0;
							end
							PH_SRD: begin
								rd = 1'b1;
							end
							PH_MRD_RESP: begin
								ex_out  = pend_q;
								phase_d = PH_MRD;
								cnt_d   = '0;
							end
							PH_MRD: begin
								// a new command start byte cuts the stream
								if (in_byte[7:6] == START_BITS) begin
									phase_d = PH_CMD;
									take    = 1'b1;
								end else begin
									rd = 1'b1;
								end
							end
							PH_WR_RESP: begin
								ex_out  = pend_q;
								phase_d = PH_WR;
								cnt_d   = '0;
							end
							PH_WR: begin
								if ({1'b0, cnt_q} >= blp4_q) begin
									ex_out  = DATA_ACCEPT;
									phase_d = PH_IDLE;
									cnt_d   = '0;
								end else if ({1'b0, cnt_q} >= blp2_q) begin
									cnt_d = cnt_q + 32'd1;
								end else if (cnt_q > 32'd1) begin
									mem_req.we = 1'b1;
									pos_d      = pos_q + 1'b1;
									cnt_d      = cnt_q + 32'd1;
								end else if (in_byte == DATA_TOKEN || cnt_q == 32'd0) begin
									cnt_d = cnt_q + 32'd1;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase

						// block read sequence: token, data, two CRC bytes, end marker
						if (rd) begin
							if (cnt_q == 32'd0) begin
								ex_out = DATA_TOKEN;
								cnt_d  = 32'd1;
							end else if ({1'b0, cnt_q} > blp2_q) begin
								cnt_d = '0;
								if (phase_q == PH_SRD) begin
									phase_d = PH_IDLE;
								end
							end else if (cnt_q > bl_q) begin
								cnt_d = cnt_q + 32'd1;
							end else begin
								ex_out = rdata;
								pos_d  = pos_q + 1'b1;
								cnt_d  = cnt_q + 32'd1;
							end
						end

						// gather a frame byte, decode after the sixth
						if (take) begin
							if (tcnt < 32'(FRAME_KEEP)) begin
								frame_we  = 1'b1;
								frame_idx = tcnt[2:0];
							end
							cnt_d = tcnt + 32'd1;
							if (tcnt >= 32'(FRAME_KEEP)) begin
								cnt_d = '0;
								case (frame_q[0][5:0])
									CMD_GO_IDLE: begin
										pend_d  = R1_IDLE;
										phase_d = PH_RESP;
									end
									CMD_SEND_OP, CMD_STOP: begin
										pend_d  = R1_READY;
										phase_d = PH_RESP;
									end
									CMD_SET_BLKLEN: begin
										bl_d    = arg;
										blp2_d  = {1'b0, arg} + 33'd2;
										blp4_d  = {1'b0, arg} + 33'd4;
										pend_d  = R1_READY;
										phase_d = PH_RESP;
									end
									CMD_READ_ONE: begin
										pos_d   = arg[sdc_pkg::POS_W-1:0];
										pend_d  = R1_READY;
										phase_d = PH_SRD_RESP;
									end
									CMD_READ_MULTI: begin
										pos_d   = arg[sdc_pkg::POS_W-1:0];
										pend_d  = R1_READY;
										phase_d = PH_MRD_RESP;
									end
									CMD_WRITE_ONE: begin
										pos_d   = arg[sdc_pkg::POS_W-1:0];
										pend_d  = R1_READY;
										phase_d = PH_WR_RESP;
									end
									default: begin
										phase_d = PH_IDLE;
									end
								endcase
							end
						end
					end
					rx_d = card_present ? ex_out : sdc_pkg::BYTE_IDLE;
					tx_d = sdc_pkg::BYTE_IDLE;
				end
				sdc_pkg::ADDR_SELECT: begin
					if (card_present && !sel_q) begin
						phase_d = PH_IDLE;
					end
					sel_d = 1'b1;
				end
				default: begin
					sel_d = 1'b0;
				end
			endcase
		end

		mem_req.raddr = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q    <= sdc_pkg::BYTE_IDLE;
			rx_q    <= sdc_pkg::BYTE_IDLE;
			sel_q   <= 1'b0;
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			pend_q  <= sdc_pkg::BYTE_IDLE;
			bl_q    <= 32'd512;
			blp2_q  <= 33'd514;
			blp4_q  <= 33'd516;
			pos_q   <= '0;
		end else begin
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			sel_q   <= sel_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
			bl_q    <= bl_d;
			blp2_q  <= blp2_d;
			blp4_q  <= blp4_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_q[frame_idx] <= in_byte;
		end
	end

endmodule

`default_nettype wire

/* src/sd_card_spi_slave.sv */
// Top level of the SPI-mode SD card model: handshakes, image store, clear sweep.
// Depends on sdc_pkg, sdc_image_ram and sdc_card_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - Input channel (in_valid/in_ready) carries one bus access per beat:
//    action (0 write, 1 read), bus_addr and bus_data.
//  - Output channel (out_valid/out_ready) returns one read_data byte per
//    accepted access; writes and unmapped reads return 0xFF.
//  - Config channel (cfg_valid/cfg_ready) writes card_present; always ready.
//  - Flow: an accepted access waits in stage 1, then its result shows in the
//    output register. Throughput: one access per cycle sustained while
//    out_ready stays high. The image store read for an access is issued at
//    its acceptance and overlaps the write-back of the access before it.
//  - Reset: card state goes to its defaults at once, then a clear sweep
//    writes zero to every image byte, one per cycle; in_ready stays low
//    during the sweep, config writes still land.
//  - Stall: when out_ready is low, one result holds in the output register
//    and one more access is taken into stage 1, where it waits; in_ready
//    then drops until the output register drains.
module sd_card_spi_slave (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [1:0] bus_addr,
	input  wire logic [7:0] bus_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	logic                          present_q;
	logic [sdc_pkg::POS_W:0]       clr_q;
	logic                          clear_done;
	logic                          v_s1;
	sdc_pkg::sdc_item_t            item_s1;
	logic                          s1_fire;
	logic                          in_fire;
	logic                          out_valid_q;
	logic [7:0]                    read_data_q;
	logic [7:0]                    result;
	logic [7:0]                    rdata;
	sdc_pkg::sdc_mem_req_t         core_req;
	logic                          ram_we;
	logic [sdc_pkg::POS_W-1:0]     ram_waddr;
	logic [7:0]                    ram_wdata;

	// the top bit of the sweep counter marks the end of the clear pass
	assign clear_done = clr_q[sdc_pkg::POS_W];

	// stage 1 advances whenever the output register is empty or draining
	assign s1_fire  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = clear_done && (!v_s1 || s1_fire);
	assign in_fire  = in_valid && in_ready;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			present_q <= cfg_data;
		end
	end

	// clear sweep: advance one image byte per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clear_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// stage 1 holds the accepted beat while its image byte is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.action <= action;
			item_s1.addr   <= bus_addr;
			item_s1.data   <= bus_data;
		end
	end

	// output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			read_data_q <= result;
		end
	end

	sdc_card_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s1_fire),
		.item         (item_s1),
		.card_present (present_q),
		.rdata        (rdata),
		.result       (result),
		.mem_req      (core_req)
	);

	// during the sweep the counter owns the write port
	assign ram_we    = clear_done ? core_req.we : 1'b1;
	assign ram_waddr = clear_done ? core_req.waddr : clr_q[sdc_pkg::POS_W-1:0];
	assign ram_wdata = clear_done ? core_req.wdata : 8'h00;

	// read is issued at acceptance, at the position left by the beat in stage 1
	sdc_image_ram #(
		.ADDR_W (sdc_pkg::POS_W),
		.DATA_W (8)
	) u_image (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire),
		.raddr (core_req.raddr),
		.rdata (rdata)
	);

	// a beat waiting in stage 1 is neither dropped nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_fire |=> v_s1 && $stable(item_s1))
		else $error("stage 1 beat lost while stalled");

	// every accepted beat reaches stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> v_s1)
		else $error("accepted beat missing from stage 1");

	// a bus write always returns the idle byte
	a_write_ff: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && item_s1.action == sdc_pkg::ACT_WRITE |=>
		out_valid_q && read_data_q == sdc_pkg::BYTE_IDLE)
		else $error("write beat returned a data byte");

	// nothing is in flight while the image store is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !v_s1 && !out_valid_q)
		else $error("beat in flight during clear sweep");

endmodule

`default_nettype wire
